// File: hw/rtl/lru_page_cache_assert.svh
// Assertion macros used by the checker file.
`ifndef LRU_PAGE_CACHE_ASSERT_SVH
`define LRU_PAGE_CACHE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define LPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define LPC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/lpc_pkg.sv
package lpc_pkg;

  localparam int unsigned CACHE_DEPTH = 8;
  localparam int unsigned PAGE_W      = 32;
  localparam int unsigned OCC_W       = 4;
  localparam int unsigned IDX_W       = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(CACHE_DEPTH + 1);

  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_FRONT
  } lpc_state_e;

endpackage

// File: hw/rtl/lru_page_cache.sv
// LRU page cache: holds up to CACHE_DEPTH page numbers in a single-port-write,
// registered-read array ordered most to least recently used. Each reference
// is one input transaction and yields exactly one result transaction. One
// shared 32-bit comparator scans the entries one per cycle, then the same
// array port moves the younger entries back one place per cycle and the page
// is written at the front. The scan covers the entries up to the hit, or all
// occupied entries on a miss; the moves cover the entries before the hit, all
// occupied entries on a miss, or CACHE_DEPTH-1 when full. The first page into
// an empty cache is not scanned. in_stall_o is high for the whole reference.
// A finished result sits in the output register while the next reference is
// taken; the block only holds at its last step if that earlier result is
// still unread.
module lru_page_cache
  import lpc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [31:0]       page_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              hit_o,
  output logic              evicted_o,
  output logic [31:0]       evicted_page_o,
  output logic [OCC_W-1:0]  occupancy_o
);

  localparam cnt_t DEPTH_C = CNT_W'(CACHE_DEPTH);
  localparam idx_t LAST_C  = IDX_W'(CACHE_DEPTH - 1);

  lpc_state_e state_q, state_d;

  page_t mem [CACHE_DEPTH];
  page_t rd_q;
  logic  re;
  idx_t  raddr;
  logic  we;
  idx_t  waddr;
  page_t wdata;

  page_t page_q, page_d;
  cnt_t  count_q, count_d;
  idx_t  ridx_q, ridx_d;
  idx_t  cidx_q, cidx_d;
  logic  pend_q, pend_d;
  idx_t  sptr_q, sptr_d;
  cnt_t  rem_q, rem_d;
  logic  wpend_q, wpend_d;
  idx_t  wptr_q, wptr_d;
  logic  hit_q, hit_d;
  logic  ev_q, ev_d;
  page_t victim_q, victim_d;

  logic       ov_q, ov_d;
  logic       ohit_q, ohit_d;
  logic       oev_q, oev_d;
  page_t      opage_q, opage_d;
  logic [OCC_W-1:0] oocc_q, oocc_d;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
      wpend_q <= 1'b0;
      rem_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      wpend_q <= wpend_d;
      rem_q   <= rem_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q   <= page_d;
    ridx_q   <= ridx_d;
    cidx_q   <= cidx_d;
    sptr_q   <= sptr_d;
    wptr_q   <= wptr_d;
    hit_q    <= hit_d;
    ev_q     <= ev_d;
    victim_q <= victim_d;
    ohit_q   <= ohit_d;
    oev_q    <= oev_d;
    opage_q  <= opage_d;
    oocc_q   <= oocc_d;
  end

  always_comb begin
    idx_t upto;
    state_d  = state_q;
    page_d   = page_q;
    count_d  = count_q;
    ridx_d   = ridx_q;
    cidx_d   = cidx_q;
    pend_d   = pend_q;
    sptr_d   = sptr_q;
    rem_d    = rem_q;
    wpend_d  = 1'b0;
    wptr_d   = wptr_q;
    hit_d    = hit_q;
    ev_d     = ev_q;
    victim_d = victim_q;
    ov_d     = ov_q;
    ohit_d   = ohit_q;
    oev_d    = oev_q;
    opage_d  = opage_q;
    oocc_d   = oocc_q;
    re       = 1'b0;
    raddr    = ridx_q;
    we       = 1'b0;
    waddr    = wptr_q;
    wdata    = rd_q;
    upto     = '0;

    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          page_d   = page_i;
          hit_d    = 1'b0;
          ev_d     = 1'b0;
          victim_d = '0;
          ridx_d   = '0;
          pend_d   = 1'b0;
          if (count_q == '0) begin
            count_d = CNT_W'(1);
            rem_d   = '0;
            state_d = ST_SHIFT;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        re     = 1'b1;
        raddr  = ridx_q;
        ridx_d = ridx_q + IDX_W'(1);
        cidx_d = ridx_q;
        pend_d = 1'b1;
        if (pend_q) begin
          if (rd_q == page_q) begin
            hit_d   = 1'b1;
            upto    = cidx_q;
            state_d = ST_SHIFT;
          end else if (CNT_W'(cidx_q) == count_q - CNT_W'(1)) begin
            if (count_q == DEPTH_C) begin
              ev_d     = 1'b1;
              victim_d = rd_q;
              upto     = LAST_C;
            end else begin
              upto    = IDX_W'(count_q);
              count_d = count_q + CNT_W'(1);
            end
            state_d = ST_SHIFT;
          end
          if (state_d == ST_SHIFT) begin
            pend_d = 1'b0;
            rem_d  = CNT_W'(upto);
            sptr_d = upto - IDX_W'(1);
          end
        end
      end

      ST_SHIFT: begin
        if (wpend_q) begin
          we    = 1'b1;
          waddr = wptr_q;
          wdata = rd_q;
        end
        if (rem_q != '0) begin
          re      = 1'b1;
          raddr   = sptr_q;
          sptr_d  = sptr_q - IDX_W'(1);
          rem_d   = rem_q - CNT_W'(1);
          wpend_d = 1'b1;
          wptr_d  = sptr_q + IDX_W'(1);
        end else begin
          state_d = ST_FRONT;
        end
      end

      ST_FRONT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = page_q;
        if (!ov_q || !out_stall_i) begin
          ov_d    = 1'b1;
          ohit_d  = hit_q;
          oev_d   = ev_q;
          opage_d = victim_q;
          oocc_d  = OCC_W'(count_q);
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = ov_q;
  assign hit_o          = ohit_q;
  assign evicted_o      = oev_q;
  assign evicted_page_o = opage_q;
  assign occupancy_o    = oocc_q;

endmodule

// File: hw/rtl/lpc_checker.sv
`include "lru_page_cache_assert.svh"

module lpc_checker
  import lpc_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic             hit_o,
  input logic             evicted_o,
  input logic [31:0]      evicted_page_o,
  input logic [OCC_W-1:0] occupancy_o
);

  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(CACHE_DEPTH);

  logic in_acc;
  logic full_miss;
  logic victim_clr;
  logic out_held;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign full_miss  = !hit_o && (occupancy_o == FULL_OCC);
  assign victim_clr = (evicted_page_o == '0);
  assign out_held   = out_valid_o && out_stall_i;

  `LPC_ASSERT_NXT(a_busy_after_accept, in_acc, in_stall_o, "not busy after accept")
  `LPC_ASSERT_IMP(a_evict_only_full_miss, out_valid_o && evicted_o, full_miss, "bad eviction")
  `LPC_ASSERT_IMP(a_victim_zero, out_valid_o && !evicted_o, victim_clr, "victim page not zero")
  `LPC_ASSERT_IMP(a_occ_nonzero, out_valid_o, occupancy_o != '0, "empty cache after reference")
  `LPC_ASSERT_NXT(a_out_hold, out_held, out_valid_o && $stable(occupancy_o), "result changed")

endmodule

bind lru_page_cache lpc_checker u_lpc_checker (.*);

// File: sim/lru_page_cache_tb.sv
module lru_page_cache_tb;
  import lpc_pkg::*;

  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned RAND_ITEMS = 1900;

  typedef struct packed {
    logic             hit;
    logic             evicted;
    page_t            evicted_page;
    logic [OCC_W-1:0] occupancy;
  } ref_outcome_t;

  class page_ref_tracker;
    page_t        lines[CACHE_DEPTH];
    int unsigned  fill;
    ref_outcome_t awaited[$];
    int unsigned  mismatches;

    function new();
      fill       = 0;
      mismatches = 0;
      foreach (lines[i]) lines[i] = '0;
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction

    function void shift_in(int unsigned upto, page_t p);
      int unsigned top;
      top = (upto > CACHE_DEPTH - 1) ? CACHE_DEPTH - 1 : upto;
      for (int unsigned i = top; i > 0; i--) lines[i] = lines[i-1];
      lines[0] = p;
    endfunction

    function void note_reference(page_t p);
      ref_outcome_t o;
      int unsigned  pos;
      bit           found;
      found = 0;
      pos   = 0;
      o     = '0;
      for (int unsigned i = 0; i < fill; i++) begin
        if (!found && lines[i] == p) begin
          found = 1;
          pos   = i;
        end
      end
      if (found) begin
        o.hit = 1'b1;
        shift_in(pos, p);
      end else if (fill == CACHE_DEPTH) begin
        o.evicted      = 1'b1;
        o.evicted_page = lines[CACHE_DEPTH-1];
        shift_in(CACHE_DEPTH - 1, p);
      end else begin
        shift_in(fill, p);
        fill++;
      end
      o.occupancy = fill[OCC_W-1:0];
      awaited.push_back(o);
    endfunction

    function void check_outcome(ref_outcome_t got);
      ref_outcome_t exp_o;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: hit=%0b ev=%0b evp=%h occ=%0d",
                   got.hit, got.evicted, got.evicted_page, got.occupancy);
        return;
      end
      exp_o = awaited.pop_front();
      if (got.hit !== exp_o.hit || got.evicted !== exp_o.evicted ||
          got.evicted_page !== exp_o.evicted_page || got.occupancy !== exp_o.occupancy) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp hit=%0b ev=%0b evp=%h occ=%0d, got hit=%0b ev=%0b evp=%h occ=%0d",
                   exp_o.hit, exp_o.evicted, exp_o.evicted_page, exp_o.occupancy,
                   got.hit, got.evicted, got.evicted_page, got.occupancy);
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic [31:0]      page = '0;
  logic             out_stall = 1'b0;
  logic             in_stall_o;
  logic             out_valid_o;
  logic             hit_o;
  logic             evicted_o;
  logic [31:0]      evicted_page_o;
  logic [OCC_W-1:0] occupancy_o;

  page_ref_tracker tracker = new();
  bit              quiet_phase = 1'b0;
  int unsigned     idle_cycles = 0;

  lru_page_cache u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .page_i         (page),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .hit_o          (hit_o),
    .evicted_o      (evicted_o),
    .evicted_page_o (evicted_page_o),
    .occupancy_o    (occupancy_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // valid stays high across back-to-back transactions when no gap is drawn
  task automatic send_page(input page_t p);
    int unsigned gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    page     <= p;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_reference(p);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic collect_results();
    int unsigned  gap;
    ref_outcome_t got;
    forever begin
      gap = quiet_phase ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got.hit          = hit_o;
      got.evicted      = evicted_o;
      got.evicted_page = evicted_page_o;
      got.occupancy    = occupancy_o;
      tracker.check_outcome(got);
    end
  endtask

  function automatic page_t edge_page();
    case ($urandom_range(0, 3))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      default: return 32'h0000_0001;
    endcase
  endfunction

  initial begin
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    collect_results();
  end

  initial begin
    page_t       pool[16];
    int unsigned pool_len;
    int unsigned sent;
    int unsigned phase_len;
    page_t       p;

    repeat (7) @(posedge clk_i);

    // fill to capacity, zero is an ordinary page
    send_page(32'h0000_0000);
    send_page(32'h0000_0000);
    send_page(32'hFFFF_FFFF);
    send_page(32'h8000_0000);
    send_page(32'h0000_0001);
    send_page(32'h5555_5555);
    send_page(32'hAAAA_AAAA);
    send_page(32'h7FFF_FFFF);
    send_page(32'h0000_0002);
    // hit at front, hit at tail
    send_page(32'h0000_0002);
    send_page(32'h0000_0000);
    // evictions and hits on a full cache
    send_page(32'h0000_0003);
    send_page(32'h0000_0000);
    send_page(32'hDEAD_BEEF);
    send_page(32'hFFFF_FFFF);
    send_page(32'h5555_5555);
    send_page(32'h0000_0001);
    drain_results();

    sent = 0;
    while (sent < RAND_ITEMS) begin
      quiet_phase = ($urandom_range(0, 3) == 0);
      pool_len    = $urandom_range(2, 16);
      for (int unsigned i = 0; i < pool_len; i++)
        pool[i] = ($urandom_range(0, 7) == 0) ? edge_page() : $urandom;
      phase_len = $urandom_range(40, 140);
      for (int unsigned n = 0; n < phase_len && sent < RAND_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 85)
          p = pool[$urandom_range(0, pool_len - 1)];
        else
          p = $urandom;
        send_page(p);
        sent++;
      end
      if ($urandom_range(0, 4) == 0) drain_results();
    end

    quiet_phase = 1'b0;
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
